// File: design/ces_pkg.sv
`timescale 1ns / 1ps
package ces_pkg;

    localparam int SampleW  = 16;
    localparam int LenW     = 16;
    localparam int SumW     = SampleW + LenW;
    localparam int ThrW     = 12;
    localparam int CfgDataW = 16;
    localparam int CfgIdxW  = 3;

    localparam logic [LenW-1:0] MaxEventLen = 16'hFFFF;

    // event queue between segmenter and classifier
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = QPtrW + 1;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegJoinThr = 3'd0;
    localparam logic [CfgIdxW-1:0] RegC0Low   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegC0High  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegC1Low   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegC1High  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegC2Low   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegC2High  = 3'd6;

    // register reset values
    localparam logic [ThrW-1:0]            JoinThrReset = 12'd32;
    localparam logic signed [SampleW-1:0]  C0LowReset   = 16'sd640;
    localparam logic signed [SampleW-1:0]  C0HighReset  = 16'sd720;
    localparam logic signed [SampleW-1:0]  C1LowReset   = 16'sd800;
    localparam logic signed [SampleW-1:0]  C1HighReset  = 16'sd960;
    localparam logic signed [SampleW-1:0]  C2LowReset   = 16'sd1200;
    localparam logic signed [SampleW-1:0]  C2HighReset  = 16'sd1360;

    // class codes
    localparam logic [1:0] ClassAaa     = 2'd0;
    localparam logic [1:0] ClassCgt     = 2'd1;
    localparam logic [1:0] ClassTac     = 2'd2;
    localparam logic [1:0] ClassUnknown = 2'd3;

    typedef struct packed {
        logic                en;
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [SampleW-1:0] mean;
        logic [LenW-1:0]           length;
        logic                      done;
        logic                      last;
    } t_event;

    typedef struct packed {
        logic [1:0]                class_code;
        logic signed [SampleW-1:0] mean;
        logic [LenW-1:0]           length;
        logic                      done;
        logic                      last;
    } t_result;

endpackage

// File: design/ces_seg.sv
`timescale 1ns / 1ps
module ces_seg
    import ces_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg_wr                   i_cfg,
    input  logic                      i_push,
    input  logic signed [SampleW-1:0] i_sample,
    input  logic                      i_end_of_read,
    output logic                      o_full,
    input  logic [QCntW-1:0]          i_q_count,
    output logic                      o_q_push,
    output t_event                    o_q_rec
);

    localparam int DivSteps = SumW;
    localparam int StepW    = $clog2(DivSteps);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV} t_state;

    t_state                    r_state;
    logic [ThrW-1:0]           r_thr;
    logic signed [SumW-1:0]    r_sum;
    logic [LenW-1:0]           r_count;
    logic                      r_open;
    logic signed [SampleW-1:0] r_mean;
    logic                      r_eor;
    logic [SumW-1:0]           r_dvd;
    logic [LenW-1:0]           r_rem;
    logic                      r_neg;
    logic [StepW-1:0]          r_step;
    logic                      r_q_push;
    t_event                    r_q_rec;

    logic                      accept;
    logic signed [SumW-1:0]    s_ext;
    logic signed [SampleW:0]   diff;
    logic [SampleW:0]          abs_diff;
    logic                      join_ok;
    logic [LenW:0]             rem_shift;
    logic [LenW+1:0]           trial;
    logic                      q_bit;
    logic [SumW-1:0]           q_final;
    logic signed [SampleW-1:0] div_mean;

    assign o_full = !(r_state == S_IDLE && !r_q_push
                      && i_q_count <= QCntW'(QDepth - 2));
    assign accept = i_push && !o_full;

    always_comb begin
        s_ext    = SumW'(i_sample);
        diff     = {i_sample[SampleW-1], i_sample} - {r_mean[SampleW-1], r_mean};
        abs_diff = diff[SampleW] ? (SampleW+1)'(-diff) : (SampleW+1)'(diff);
        join_ok  = r_open && (abs_diff < (SampleW+1)'(r_thr)) && (r_count != MaxEventLen);

        // one restoring step of |sum| / count
        rem_shift = {r_rem, r_dvd[SumW-1]};
        trial     = {1'b0, rem_shift} - {2'b00, r_count};
        q_bit     = !trial[LenW+1];
        q_final   = {r_dvd[SumW-2:0], q_bit};
        div_mean  = r_neg ? SampleW'(-q_final[SampleW-1:0]) : q_final[SampleW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= JoinThrReset;
            r_sum    <= '0;
            r_count  <= '0;
            r_open   <= 1'b0;
            r_mean   <= '0;
            r_eor    <= 1'b0;
            r_q_push <= 1'b0;
            r_step   <= '0;
        end else begin
            r_q_push <= 1'b0;
            if (i_cfg.en && i_cfg.index == RegJoinThr) begin
                r_thr <= i_cfg.data[ThrW-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_eor  <= i_end_of_read;
                        r_open <= 1'b1;
                        if (join_ok) begin
                            r_sum   <= r_sum + s_ext;
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_sum   <= s_ext;
                            r_count <= LenW'(1);
                        end
                        // the open event closes on this sample
                        if (r_open && !join_ok) begin
                            r_q_push       <= 1'b1;
                            r_q_rec.mean   <= r_mean;
                            r_q_rec.length <= r_count;
                            r_q_rec.done   <= 1'b0;
                            r_q_rec.last   <= !i_end_of_read;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_neg   <= r_sum[SumW-1];
                    r_dvd   <= r_sum[SumW-1] ? SumW'(-r_sum) : SumW'(r_sum);
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dvd  <= q_final;
                    r_rem  <= q_bit ? trial[LenW-1:0] : rem_shift[LenW-1:0];
                    r_step <= r_step + 1'b1;
                    if (r_step == StepW'(DivSteps - 1)) begin
                        r_mean  <= div_mean;
                        r_state <= S_IDLE;
                        if (r_eor) begin
                            r_q_push       <= 1'b1;
                            r_q_rec.mean   <= div_mean;
                            r_q_rec.length <= r_count;
                            r_q_rec.done   <= 1'b1;
                            r_q_rec.last   <= 1'b1;
                            r_sum          <= '0;
                            r_count        <= '0;
                            r_open         <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_q_push = r_q_push;
    assign o_q_rec  = r_q_rec;

endmodule

// File: design/ces_evq.sv
`timescale 1ns / 1ps
module ces_evq
    import ces_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  t_event           i_wr_rec,
    input  logic             i_rd,
    output t_event           o_rd_rec,
    output logic             o_empty,
    output logic [QCntW-1:0] o_count
);

    t_event            r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr;
    logic [QPtrW-1:0]  r_rd_ptr;
    logic [QCntW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rd_rec = r_mem[r_rd_ptr];
    assign o_empty  = (r_count == '0);
    assign o_count  = r_count;

endmodule

// File: design/ces_cls.sv
`timescale 1ns / 1ps
module ces_cls
    import ces_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_q_empty,
    input  t_event  i_q_rec,
    output logic    o_q_pop,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_pop
);

    logic signed [SampleW-1:0] r_c0_lo, r_c0_hi;
    logic signed [SampleW-1:0] r_c1_lo, r_c1_hi;
    logic signed [SampleW-1:0] r_c2_lo, r_c2_hi;
    logic                      r_valid;
    t_result                   r_res;
    logic [1:0]                class_code;

    always_comb begin
        if (i_q_rec.mean >= r_c0_lo && i_q_rec.mean <= r_c0_hi) begin
            class_code = ClassAaa;
        end else if (i_q_rec.mean >= r_c1_lo && i_q_rec.mean <= r_c1_hi) begin
            class_code = ClassCgt;
        end else if (i_q_rec.mean >= r_c2_lo && i_q_rec.mean <= r_c2_hi) begin
            class_code = ClassTac;
        end else begin
            class_code = ClassUnknown;
        end
    end

    // refill the output stage when it is empty or being taken
    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_lo <= C0LowReset;
            r_c0_hi <= C0HighReset;
            r_c1_lo <= C1LowReset;
            r_c1_hi <= C1HighReset;
            r_c2_lo <= C2LowReset;
            r_c2_hi <= C2HighReset;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg.en) begin
                case (i_cfg.index)
                    RegC0Low:  r_c0_lo <= i_cfg.data;
                    RegC0High: r_c0_hi <= i_cfg.data;
                    RegC1Low:  r_c1_lo <= i_cfg.data;
                    RegC1High: r_c1_hi <= i_cfg.data;
                    RegC2Low:  r_c2_lo <= i_cfg.data;
                    RegC2High: r_c2_hi <= i_cfg.data;
                    default:   ;
                endcase
            end
            if (o_q_pop) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res.class_code <= class_code;
            r_res.mean       <= i_q_rec.mean;
            r_res.length     <= i_q_rec.length;
            r_res.done       <= i_q_rec.done;
            r_res.last       <= i_q_rec.last;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: design/current_event_segmenter_classifier_core.sv
`timescale 1ns / 1ps
// Current event segmenter and classifier.
// Input queue side: drive i_sample and i_end_of_read with push; a request is
// taken at a clock edge where push is high and full is low. Result queue side:
// while empty is low the oldest event is on the o_* result ports; pop takes it.
// Each sample either joins the open event or closes it; a closed event, and
// the event open at end of read, come out with mean, length and class code.
// Configuration: write i_cfg_wdata to register i_cfg_index with i_cfg_wr_en,
// only while the block is idle; writes take effect at the next edge.
// A new sample is not taken until the last one has been fully processed.
// After each sample the event mean is rebuilt by a radix-2 divider, one
// quotient bit per cycle over the 32-bit event sum, and full stays high
// until it finishes.
// A closed event reaches the result ports via the push register, the event
// queue and the output register; the end-of-read event once its mean is done.
// If the receiver stalls, up to four events wait in the internal queue plus
// one in the output register; full rises once fewer than two queue slots are
// free. Reset (synchronous, i_rst_n low) drops any open event and queued
// results and returns all registers to their defaults.
module current_event_segmenter_classifier_core
    import ces_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [CfgDataW-1:0]       i_cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  logic signed [SampleW-1:0] i_sample,
    input  logic                      i_end_of_read,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                o_class_code,
    output logic signed [SampleW-1:0] o_event_mean,
    output logic [LenW-1:0]           o_event_length,
    output logic                      o_read_done,
    output logic                      o_last_of_run
);

    t_cfg_wr          cfg;
    logic             q_push;
    t_event           q_wr_rec;
    logic             q_pop;
    t_event           q_rd_rec;
    logic             q_empty;
    logic [QCntW-1:0] q_count;
    logic             out_valid;
    t_result          out_res;

    assign cfg.en    = i_cfg_wr_en;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_wdata;

    ces_seg u_seg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .i_sample      (i_sample),
        .i_end_of_read (i_end_of_read),
        .o_full        (full),
        .i_q_count     (q_count),
        .o_q_push      (q_push),
        .o_q_rec       (q_wr_rec)
    );

    ces_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_push),
        .i_wr_rec (q_wr_rec),
        .i_rd     (q_pop),
        .o_rd_rec (q_rd_rec),
        .o_empty  (q_empty),
        .o_count  (q_count)
    );

    ces_cls u_cls (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_rec   (q_rd_rec),
        .o_q_pop   (q_pop),
        .o_valid   (out_valid),
        .o_res     (out_res),
        .i_pop     (pop)
    );

    assign empty          = !out_valid;
    assign o_class_code   = out_res.class_code;
    assign o_event_mean   = out_res.mean;
    assign o_event_length = out_res.length;
    assign o_read_done    = out_res.done;
    assign o_last_of_run  = out_res.last;

endmodule
